// File: hdl/rc4_pkg.sv
// rc4 package: shared types, state encoding and sizes
`timescale 1ns / 1ps
package rc4_pkg;

  localparam int PERM_DEPTH    = 256;
  localparam int PERM_AW       = $clog2(PERM_DEPTH);
  localparam int BYTE_W        = 8;
  localparam int KEY_REG_BYTES = 4;
  localparam int KEY_W         = KEY_REG_BYTES * BYTE_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KSA_RD,
    ST_KSA_J,
    ST_KSA_WN,
    ST_KSA_WJ,
    ST_GEN_I,
    ST_GEN_J,
    ST_GEN_SWAP,
    ST_GEN_OUT
  } rc4_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic in_load;
    logic fill;
    logic ksa_rd;
    logic ksa_j;
    logic ksa_wn;
    logic ksa_wj;
    logic gen_i;
    logic gen_j;
    logic gen_swap;
    logic gen_out;
    logic out_load;
    logic idx_clr;
  } rc4_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cnt_last;
    logic last_flag;
    logic out_free;
  } rc4_stat_t;

endpackage

// File: hdl/rc4_ctrl.sv
// rc4 controller: sequences key schedule and keystream steps
`timescale 1ns / 1ps
module rc4_ctrl import rc4_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rc4_stat_t stat_i,
  output rc4_cmd_t  cmd_o
);

  rc4_state_e state_q, state_d;
  logic       pending_q, pending_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pending_q ? ST_FILL : ST_GEN_J;
        end
      end
      ST_FILL: begin
        if (stat_i.cnt_last) begin
          state_d = ST_KSA_RD;
        end
      end
      ST_KSA_RD:   state_d = ST_KSA_J;
      ST_KSA_J:    state_d = ST_KSA_WN;
      ST_KSA_WN:   state_d = ST_KSA_WJ;
      ST_KSA_WJ:   state_d = stat_i.cnt_last ? ST_GEN_I : ST_KSA_RD;
      ST_GEN_I:    state_d = ST_GEN_J;
      ST_GEN_J:    state_d = ST_GEN_SWAP;
      ST_GEN_SWAP: state_d = ST_GEN_OUT;
      ST_GEN_OUT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    pending_d  = pending_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.in_load = in_valid_i;
        cmd_o.gen_i   = in_valid_i && !pending_q;
      end
      ST_FILL:   cmd_o.fill   = 1'b1;
      ST_KSA_RD: cmd_o.ksa_rd = 1'b1;
      ST_KSA_J:  cmd_o.ksa_j  = 1'b1;
      ST_KSA_WN: cmd_o.ksa_wn = 1'b1;
      ST_KSA_WJ: begin
        cmd_o.ksa_wj  = 1'b1;
        cmd_o.idx_clr = stat_i.cnt_last;
        if (stat_i.cnt_last) begin
          pending_d = 1'b0;
        end
      end
      ST_GEN_I:    cmd_o.gen_i    = 1'b1;
      ST_GEN_J:    cmd_o.gen_j    = 1'b1;
      ST_GEN_SWAP: cmd_o.gen_swap = 1'b1;
      ST_GEN_OUT: begin
        cmd_o.gen_out  = 1'b1;
        cmd_o.out_load = stat_i.out_free;
        if (stat_i.out_free && stat_i.last_flag) begin
          pending_d = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: hdl/rc4_dp.sv
// rc4 datapath: permutation memory, indices, key select and output register
`timescale 1ns / 1ps
module rc4_dp import rc4_pkg::*; #(
  parameter int KEY_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rc4_cmd_t          cmd_i,
  output rc4_stat_t         stat_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              last_of_message_i,
  input  logic              cfg_valid_i,
  input  logic [KEY_W-1:0]  cfg_cipher_key_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] cipher_byte_o,
  output logic              last_out_o
);

  localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];

  logic [KEY_W-1:0]   key_q;
  logic [PERM_AW-1:0] cnt_q, cnt_d;
  logic [KIW-1:0]     kidx_q, kidx_d;
  logic [PERM_AW-1:0] i_q, i_d;
  logic [PERM_AW-1:0] j_q, j_d;
  logic [BYTE_W-1:0]  a_q, b_q, rd_a_q, rd_b_q;
  logic               hit_i_q, hit_j_q;
  logic [BYTE_W-1:0]  data_q;
  logic               last_q;
  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  cipher_q;
  logic               last_out_q;

  logic               wr_en, rd_a_en, rd_b_en;
  logic [PERM_AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
  logic [BYTE_W-1:0]  wr_data;
  logic [BYTE_W-1:0]  key_byte, ks;
  logic [PERM_AW-1:0] i_inc, j_ksa, j_gen, sum_idx;

  // key byte for the current schedule step, zero beyond the register
  always_comb begin
    key_byte = '0;
    for (int b = 0; b < KEY_REG_BYTES; b++) begin
      if (int'(kidx_q) == b) begin
        key_byte = key_q[b*BYTE_W +: BYTE_W];
      end
    end
  end

  assign i_inc   = i_q + PERM_AW'(1);
  assign j_ksa   = j_q + rd_a_q + key_byte;
  assign j_gen   = j_q + rd_a_q;
  assign sum_idx = a_q + rd_b_q;

  // swapped values not yet in memory are forwarded
  assign ks = hit_j_q ? a_q : (hit_i_q ? b_q : rd_a_q);

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q;
    wr_data = cnt_q;
    priority if (cmd_i.fill) begin
      wr_en = 1'b1;
    end else if (cmd_i.ksa_wn) begin
      wr_en   = 1'b1;
      wr_data = rd_b_q;
    end else if (cmd_i.ksa_wj || cmd_i.gen_out) begin
      wr_en   = 1'b1;
      wr_addr = j_q;
      wr_data = a_q;
    end else if (cmd_i.gen_swap) begin
      wr_en   = 1'b1;
      wr_addr = i_q;
      wr_data = rd_b_q;
    end
  end

  always_comb begin
    rd_a_en   = cmd_i.ksa_rd || cmd_i.gen_i || cmd_i.gen_swap;
    rd_a_addr = cnt_q;
    priority if (cmd_i.gen_i) begin
      rd_a_addr = i_inc;
    end else if (cmd_i.gen_swap) begin
      rd_a_addr = sum_idx;
    end
    rd_b_en   = cmd_i.ksa_j || cmd_i.gen_j;
    rd_b_addr = cmd_i.ksa_j ? j_ksa : j_gen;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_q <= perm_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_q <= perm_mem[rd_b_addr];
    end
  end

  // index and counter updates
  always_comb begin
    cnt_d  = cnt_q;
    kidx_d = kidx_q;
    i_d    = i_q;
    j_d    = j_q;
    if (cmd_i.fill || cmd_i.ksa_wj) begin
      cnt_d = cnt_q + PERM_AW'(1);
    end
    if (cmd_i.fill) begin
      kidx_d = '0;
      j_d    = '0;
    end
    if (cmd_i.ksa_wj) begin
      kidx_d = (kidx_q == KIW'(KEY_BYTES - 1)) ? '0 : kidx_q + KIW'(1);
    end
    if (cmd_i.ksa_j) begin
      j_d = j_ksa;
    end
    if (cmd_i.gen_j) begin
      j_d = j_gen;
    end
    if (cmd_i.gen_i) begin
      i_d = i_inc;
    end
    if (cmd_i.idx_clr) begin
      i_d = '0;
      j_d = '0;
    end
  end

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      cnt_q       <= '0;
      kidx_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        key_q <= cfg_cipher_key_i;
      end
      cnt_q       <= cnt_d;
      kidx_q      <= kidx_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      data_q <= data_byte_i;
      last_q <= last_of_message_i;
    end
    if (cmd_i.ksa_j || cmd_i.gen_j) begin
      a_q <= rd_a_q;
    end
    if (cmd_i.gen_swap) begin
      b_q     <= rd_b_q;
      hit_i_q <= (sum_idx == i_q);
      hit_j_q <= (sum_idx == j_q);
    end
    if (cmd_i.out_load) begin
      cipher_q   <= data_q ^ ks;
      last_out_q <= last_q;
    end
  end

  assign stat_o.cnt_last  = (cnt_q == PERM_AW'(PERM_DEPTH - 1));
  assign stat_o.last_flag = last_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = cipher_q;
  assign last_out_o    = last_out_q;

endmodule

// File: hdl/rc4_stream_cipher_top.sv
// rc4 stream cipher top level: controller plus datapath
`timescale 1ns / 1ps
//
// channel   | handshake                | payload
// ----------+--------------------------+-----------------------------------
// input     | in_valid_i / in_ready_o  | data_byte_i[7:0], last_of_message_i
// output    | out_valid_o / out_ready_i| cipher_byte_o[7:0], last_out_o
// config    | cfg_valid_i / cfg_ready_o| cfg_cipher_key_i[31:0]
//
// a byte runs through these steps: accept, read S[i] then S[j], swap write with the
//   keystream read, second swap write with the output register load;
//   the permutation memory (one write port, two read ports) sets this order
// the first byte of each message (and the first after reset) also runs the
//   key schedule: an identity fill of all 256 entries, then a shuffle step
//   per entry (read, j update, two swap writes), then the first keystream read
// reset is asynchronous, active low; the permutation memory is not cleared,
//   the schedule always rebuilds it before it is read
// a finished byte waits in the output register; the next request is taken
//   while it waits, and a new byte stalls only in its final step until the
//   output register is free
//
module rc4_stream_cipher_top import rc4_pkg::*; #(
  parameter int KEY_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              last_of_message_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] cipher_byte_o,
  output logic              last_out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [KEY_W-1:0]  cfg_cipher_key_i
);

  rc4_cmd_t  cmd;
  rc4_stat_t stat;

  // key writes land at once; the user must issue them only while the block is idle (not enforced)
  assign cfg_ready_o = 1'b1;

  // sequencer: schedule on message start, then one keystream step per request
  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // permutation memory, i/j indices, key byte select and result register
  rc4_dp #(
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .data_byte_i       (data_byte_i),
    .last_of_message_i (last_of_message_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_cipher_key_i  (cfg_cipher_key_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .cipher_byte_o     (cipher_byte_o),
    .last_out_o        (last_out_o)
  );

endmodule

// File: hdl/rc4_chk.sv
// rc4 port checker and its bind to the top level
`timescale 1ns / 1ps
module rc4_chk import rc4_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] cipher_byte_o,
  input logic              last_out_o
);

  // a request keeps the block busy through the j read, swap and output steps that follow
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input ready too soon after request");

  // a new result appears only as the block returns to taking requests
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared while block busy");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(cipher_byte_o) && $stable(last_out_o)))
    else $error("result payload changed while stalled");

endmodule

bind rc4_stream_cipher_top rc4_chk u_chk (.*);
